[hdl/allocation_tracker_hash_table_defines.svh]
// assertion macros for the allocation tracker
// no dependencies; users need clk and arst_n in scope
`ifndef ALLOCATION_TRACKER_HASH_TABLE_DEFINES_SVH
`define ALLOCATION_TRACKER_HASH_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ATH_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocation tracker: implication check failed");
`define ATH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocation tracker: next-cycle check failed");
`else
`define ATH_ASSERT_IMP(label, ante, cons)
`define ATH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/ath_pkg.sv]
// shared types and constants of the allocation tracker hash table
// no dependencies
package ath_pkg;

	// table geometry
	localparam int SLOTS         = 1024;
	localparam int SLOT_W        = $clog2(SLOTS);
	localparam int CNT_W         = $clog2(SLOTS + 1);
	localparam int LOCATION_BITS = 16;
	localparam int NUM_KINDS     = 6;

	// fixed field widths
	localparam int KEY_W       = 64;
	localparam int HALF_W      = 32;
	localparam int KIND_W      = 3;
	localparam int SIZE_W      = 48;
	localparam int LOC_IN_W    = 16;
	localparam int STATUS_W    = 2;
	localparam int SLOT_IDX_W  = 10;
	localparam int OCC_W       = 11;
	localparam int TOTAL_W     = 64;

	// kind codes with special remove behavior
	localparam logic [KIND_W-1:0] KIND_MALLOC = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CALLOC = 3'd1;

	typedef enum logic {
		REQ_ADD,
		REQ_REMOVE
	} req_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_FULL,
		ST_NOT_FOUND,
		ST_ZERO_KEY
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE,
		S_UPDATE,
		S_REPORT
	} state_t;

	// one table entry as stored in the slot memory
	typedef struct packed {
		logic [KEY_W-1:0]         key;
		logic [KIND_W-1:0]        kind;
		logic [SIZE_W-1:0]        size;
		logic [LOCATION_BITS-1:0] loc;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

[hdl/ath_req_if.sv]
// request channel: valid/ready handshake with the request fields
// depends on ath_pkg
interface ath_req_if;
	logic                            valid;
	logic                            ready;
	logic                            req_type;
	logic [ath_pkg::KEY_W-1:0]       key;
	logic [ath_pkg::KIND_W-1:0]      kind;
	logic [ath_pkg::SIZE_W-1:0]      size_amount;
	logic [ath_pkg::LOC_IN_W-1:0]    location_id;

	modport source (output valid, req_type, key, kind, size_amount, location_id, input ready);
	modport sink (input valid, req_type, key, kind, size_amount, location_id, output ready);
endinterface

[hdl/ath_rsp_if.sv]
// response channel: valid/ready handshake with the result fields
// depends on ath_pkg
interface ath_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [ath_pkg::STATUS_W-1:0]     status;
	logic [ath_pkg::SLOT_IDX_W-1:0]   slot_index;
	logic [ath_pkg::OCC_W-1:0]        occupied_count;
	logic [ath_pkg::TOTAL_W-1:0]      kind_total;

	modport source (output valid, status, slot_index, occupied_count, kind_total, input ready);
	modport sink (input valid, status, slot_index, occupied_count, kind_total, output ready);
endinterface

[hdl/allocation_tracker_hash_table.sv]
// Allocation tracker: open-addressed table with linear probing over one slot memory.
// A request is probed from its home slot, one probe per cycle, and its result goes to the
// result register; the next item is taken only once that result is loaded. A miss or a
// full table (all 1024 slots) ends after every slot is probed. A zero key skips the probe.
// Reset: counters and totals clear at once, then a clearing pass empties the slot memory,
// during which no item is taken.
`include "allocation_tracker_hash_table_defines.svh"

module allocation_tracker_hash_table (
	input  logic         clk,
	input  logic         arst_n,
	ath_req_if.sink      req,
	ath_rsp_if.source    rsp
);

	ath_pkg::state_t state_q, state_d;

	// captured request
	ath_pkg::req_kind_t                  type_q;
	logic [ath_pkg::KEY_W-1:0]           key_q;
	logic [ath_pkg::KIND_W-1:0]          kind_q;
	logic [ath_pkg::SIZE_W-1:0]          size_q;
	logic [ath_pkg::LOCATION_BITS-1:0]   loc_q;

	// probe control
	logic [ath_pkg::SLOT_W-1:0]  rd_addr_q;
	logic [ath_pkg::CNT_W-1:0]   iss_cnt_q;
	logic [ath_pkg::CNT_W-1:0]   chk_cnt_q;
	logic                        rv_s1;
	logic [ath_pkg::SLOT_W-1:0]  ridx_s1;
	logic [ath_pkg::SLOT_W-1:0]  clr_addr_q;

	// probe result
	logic [ath_pkg::SLOT_W-1:0]  hit_slot_q;
	logic [ath_pkg::KIND_W-1:0]  hit_kind_q;
	logic [ath_pkg::SIZE_W-1:0]  hit_size_q;
	ath_pkg::status_t            res_status_q;
	logic [ath_pkg::SLOT_W-1:0]  res_slot_q;

	// counters and totals
	logic [ath_pkg::CNT_W-1:0]   live_q;
	logic [ath_pkg::TOTAL_W-1:0] total_q [ath_pkg::NUM_KINDS];

	// result register
	logic                           out_valid_q;
	ath_pkg::status_t               out_status_q;
	logic [ath_pkg::SLOT_W-1:0]     out_slot_q;
	logic [ath_pkg::CNT_W-1:0]      out_occ_q;
	logic [ath_pkg::TOTAL_W-1:0]    out_total_q;

	// slot memory ports
	logic                           ram_we;
	logic [ath_pkg::SLOT_W-1:0]     ram_waddr;
	logic [ath_pkg::ENTRY_W-1:0]    ram_wdata;
	logic                           ram_re;
	logic [ath_pkg::ENTRY_W-1:0]    ram_rdata;
	ath_pkg::entry_t                rd_e;
	ath_pkg::entry_t                new_e;

	logic                           accept;
	logic                           key_zero;
	logic [ath_pkg::HALF_W-1:0]     hash_sum;
	logic [ath_pkg::SLOT_W-1:0]     home;
	logic                           issue;
	logic                           match;
	logic                           hit;
	logic                           exhausted;
	logic                           load_out;
	logic [ath_pkg::SLOT_W-1:0]     next_addr;
	logic [ath_pkg::KIND_W-1:0]     upd_idx;
	logic [ath_pkg::KIND_W-1:0]     tot_rd_idx;
	logic [ath_pkg::TOTAL_W-1:0]    tot_rd;
	logic [ath_pkg::TOTAL_W-1:0]    tot_new;

	ath_ram #(
		.WIDTH (ath_pkg::ENTRY_W),
		.DEPTH (ath_pkg::SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	// home slot of the incoming key
	assign key_zero = (req.key == '0);
	assign hash_sum = req.key[ath_pkg::KEY_W-1:ath_pkg::HALF_W] + req.key[ath_pkg::HALF_W-1:0];
	assign home     = ath_pkg::SLOT_W'(hash_sum % ath_pkg::SLOTS);

	// probe check on returned memory data
	assign rd_e  = ath_pkg::entry_t'(ram_rdata);
	assign issue = (iss_cnt_q != ath_pkg::CNT_W'(ath_pkg::SLOTS));
	always_comb begin
		if (type_q == ath_pkg::REQ_ADD) begin
			match = (rd_e.key == '0);
		end else begin
			match = (rd_e.key == key_q) && ((rd_e.kind == kind_q) ||
				(rd_e.kind == ath_pkg::KIND_CALLOC && kind_q == ath_pkg::KIND_MALLOC));
		end
	end
	assign hit       = (state_q == ath_pkg::S_PROBE) && rv_s1 && match;
	assign exhausted = (state_q == ath_pkg::S_PROBE) && rv_s1 && !match &&
		(chk_cnt_q == ath_pkg::CNT_W'(ath_pkg::SLOTS - 1));
	assign next_addr = (rd_addr_q == ath_pkg::SLOT_W'(ath_pkg::SLOTS - 1)) ? '0 :
		rd_addr_q + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ath_pkg::S_CLEAR: begin
				if (clr_addr_q == ath_pkg::SLOT_W'(ath_pkg::SLOTS - 1)) begin
					state_d = ath_pkg::S_IDLE;
				end
			end
			ath_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = key_zero ? ath_pkg::S_REPORT : ath_pkg::S_PROBE;
				end
			end
			ath_pkg::S_PROBE: begin
				if (hit) begin
					state_d = ath_pkg::S_UPDATE;
				end else if (exhausted) begin
					state_d = ath_pkg::S_REPORT;
				end
			end
			ath_pkg::S_UPDATE: begin
				state_d = ath_pkg::S_REPORT;
			end
			ath_pkg::S_REPORT: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ath_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ath_pkg::S_CLEAR;
			end
		endcase
	end

	// state outputs: handshake and memory controls
	always_comb begin
		new_e.key  = key_q;
		new_e.kind = kind_q;
		new_e.size = size_q;
		new_e.loc  = loc_q;
		req.ready  = (state_q == ath_pkg::S_IDLE);
		ram_re     = (state_q == ath_pkg::S_PROBE) && issue;
		ram_we     = 1'b0;
		ram_waddr  = hit_slot_q;
		ram_wdata  = '0;
		load_out   = 1'b0;
		case (state_q)
			ath_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
			end
			ath_pkg::S_UPDATE: begin
				ram_we = 1'b1;
				if (type_q == ath_pkg::REQ_ADD) begin
					ram_wdata = new_e;
				end
			end
			ath_pkg::S_REPORT: begin
				load_out = !out_valid_q || rsp.ready;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end
	assign accept = req.valid && req.ready;

	// totals read mux: updated kind during update, request kind otherwise
	assign upd_idx    = (type_q == ath_pkg::REQ_ADD) ? kind_q : hit_kind_q;
	assign tot_rd_idx = (state_q == ath_pkg::S_UPDATE) ? upd_idx : kind_q;
	always_comb begin
		tot_rd = '0;
		for (int k = 0; k < ath_pkg::NUM_KINDS; k++) begin
			if (tot_rd_idx == ath_pkg::KIND_W'(k)) begin
				tot_rd = total_q[k];
			end
		end
	end
	assign tot_new = (type_q == ath_pkg::REQ_ADD) ?
		tot_rd + ath_pkg::TOTAL_W'(size_q) : tot_rd - ath_pkg::TOTAL_W'(hit_size_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ath_pkg::S_CLEAR;
			clr_addr_q  <= '0;
			iss_cnt_q   <= '0;
			chk_cnt_q   <= '0;
			rv_s1       <= 1'b0;
			live_q      <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < ath_pkg::NUM_KINDS; k++) begin
				total_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == ath_pkg::S_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			// probe counters
			if (accept) begin
				iss_cnt_q <= '0;
				chk_cnt_q <= '0;
			end else if (state_q == ath_pkg::S_PROBE) begin
				if (ram_re) begin
					iss_cnt_q <= iss_cnt_q + 1'b1;
				end
				if (rv_s1) begin
					chk_cnt_q <= chk_cnt_q + 1'b1;
				end
			end
			rv_s1 <= ram_re && (state_d == ath_pkg::S_PROBE);
			// occupancy and totals
			if (state_q == ath_pkg::S_UPDATE) begin
				if (type_q == ath_pkg::REQ_ADD) begin
					live_q <= live_q + 1'b1;
				end else if (live_q != '0) begin
					live_q <= live_q - 1'b1;
				end
				for (int k = 0; k < ath_pkg::NUM_KINDS; k++) begin
					if (upd_idx == ath_pkg::KIND_W'(k)) begin
						total_q[k] <= tot_new;
					end
				end
			end
			// result register handshake
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q       <= ath_pkg::req_kind_t'(req.req_type);
			key_q        <= req.key;
			kind_q       <= req.kind;
			size_q       <= req.size_amount;
			loc_q        <= ath_pkg::LOCATION_BITS'(req.location_id);
			rd_addr_q    <= home;
			res_slot_q   <= '0;
			if (key_zero && ath_pkg::req_kind_t'(req.req_type) == ath_pkg::REQ_REMOVE) begin
				res_status_q <= ath_pkg::ST_ZERO_KEY;
			end else begin
				res_status_q <= ath_pkg::ST_OK;
			end
		end else if (ram_re) begin
			rd_addr_q <= next_addr;
		end
		if (ram_re) begin
			ridx_s1 <= rd_addr_q;
		end
		if (hit) begin
			hit_slot_q   <= ridx_s1;
			hit_kind_q   <= rd_e.kind;
			hit_size_q   <= rd_e.size;
			res_slot_q   <= ridx_s1;
			res_status_q <= ath_pkg::ST_OK;
		end else if (exhausted) begin
			res_status_q <= (type_q == ath_pkg::REQ_ADD) ? ath_pkg::ST_FULL :
				ath_pkg::ST_NOT_FOUND;
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_occ_q    <= live_q;
			out_total_q  <= tot_rd;
		end
	end

	// response port
	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.slot_index     = ath_pkg::SLOT_IDX_W'(out_slot_q);
	assign rsp.occupied_count = ath_pkg::OCC_W'(out_occ_q);
	assign rsp.kind_total     = out_total_q;

	// checks
	`ATH_ASSERT_IMP(a_live_bound, 1'b1, live_q <= ath_pkg::CNT_W'(ath_pkg::SLOTS))
	`ATH_ASSERT_IMP(a_chk_bound, 1'b1, chk_cnt_q <= iss_cnt_q)
	`ATH_ASSERT_IMP(a_slot_zero, out_valid_q && out_status_q != ath_pkg::ST_OK, out_slot_q == '0)
	`ATH_ASSERT_NEXT(a_report_loads, load_out, out_valid_q && state_q == ath_pkg::S_IDLE)

endmodule

[hdl/ath_ram.sv]
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module ath_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[tb/allocation_tracker_hash_table_checker.sv]
// checker for the allocation tracker: keeps a shadow table, predicts each result, compares
// depends on ath_pkg and the ath_req_if / ath_rsp_if channel interfaces
module allocation_tracker_hash_table_checker (
	input  logic clk,
	input  logic arst_n,
	ath_req_if   req,
	ath_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding
);

	typedef struct packed {
		ath_pkg::status_t                 status;
		logic [ath_pkg::SLOT_IDX_W-1:0]   slot_index;
		logic [ath_pkg::OCC_W-1:0]        occupied_count;
		logic [ath_pkg::TOTAL_W-1:0]      kind_total;
	} outcome_t;

	ath_pkg::entry_t             slot_store [ath_pkg::SLOTS];
	logic [ath_pkg::OCC_W-1:0]   live_entries;
	logic [ath_pkg::TOTAL_W-1:0] kind_sums [ath_pkg::NUM_KINDS];
	outcome_t                    expected_outcomes [$];
	outcome_t                    oldest;
	int                          result_count;
	int                          error_count = 0;

	assign mismatches = error_count;

	task automatic report_failure(string what);
		error_count++;
		$display("result %0d: %s", result_count, what);
	endtask

	task automatic check_field(string name, logic [ath_pkg::TOTAL_W-1:0] got,
			logic [ath_pkg::TOTAL_W-1:0] want);
		if (got !== want)
			report_failure($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// one request against the shadow table: linear probe from the home slot with wrap
	function automatic outcome_t apply_request(logic op, logic [ath_pkg::KEY_W-1:0] k,
			logic [ath_pkg::KIND_W-1:0] kd, logic [ath_pkg::SIZE_W-1:0] sz,
			logic [ath_pkg::LOC_IN_W-1:0] loc);
		outcome_t                   o;
		logic [ath_pkg::HALF_W-1:0] h;
		int                         idx;
		int                         n;
		bit                         hit;
		o.status = ath_pkg::ST_OK;
		o.slot_index = '0;
		hit = 1'b0;
		h = k[ath_pkg::KEY_W-1:ath_pkg::HALF_W] + k[ath_pkg::HALF_W-1:0];
		idx = int'(h % ath_pkg::SLOTS);
		if (k == '0) begin
			// zero key: add is a quiet ok, remove is flagged
			if (op == ath_pkg::REQ_REMOVE)
				o.status = ath_pkg::ST_ZERO_KEY;
		end else if (op == ath_pkg::REQ_ADD) begin
			// first empty slot takes the entry
			for (n = 0; n < ath_pkg::SLOTS && !hit; n++) begin
				if (slot_store[idx].key == '0) begin
					slot_store[idx].key = k;
					slot_store[idx].kind = kd;
					slot_store[idx].size = sz;
					slot_store[idx].loc = loc[ath_pkg::LOCATION_BITS-1:0];
					live_entries++;
					if (kd < ath_pkg::NUM_KINDS)
						kind_sums[kd] += ath_pkg::TOTAL_W'(sz);
					o.slot_index = idx[ath_pkg::SLOT_IDX_W-1:0];
					hit = 1'b1;
				end else begin
					idx = (idx == ath_pkg::SLOTS - 1) ? 0 : idx + 1;
				end
			end
			if (!hit)
				o.status = ath_pkg::ST_FULL;
		end else begin
			// whole-table search, empty slots do not stop it; malloc also frees calloc
			for (n = 0; n < ath_pkg::SLOTS && !hit; n++) begin
				if (slot_store[idx].key == k && (slot_store[idx].kind == kd ||
						(slot_store[idx].kind == ath_pkg::KIND_CALLOC &&
						kd == ath_pkg::KIND_MALLOC))) begin
					slot_store[idx].key = '0;
					if (live_entries != '0)
						live_entries--;
					if (slot_store[idx].kind < ath_pkg::NUM_KINDS)
						kind_sums[slot_store[idx].kind] -=
							ath_pkg::TOTAL_W'(slot_store[idx].size);
					o.slot_index = idx[ath_pkg::SLOT_IDX_W-1:0];
					hit = 1'b1;
				end else begin
					idx = (idx == ath_pkg::SLOTS - 1) ? 0 : idx + 1;
				end
			end
			if (!hit)
				o.status = ath_pkg::ST_NOT_FOUND;
		end
		o.occupied_count = live_entries;
		o.kind_total = (kd < ath_pkg::NUM_KINDS) ? kind_sums[kd] : '0;
		return o;
	endfunction

	// watch both channels; results are taken before a new item is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (slot_store[s])
				slot_store[s] = '0;
			foreach (kind_sums[s])
				kind_sums[s] = '0;
			live_entries = '0;
			expected_outcomes.delete();
			result_count = 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_outcomes.size() == 0) begin
					report_failure("result arrived with no request waiting for it");
				end else begin
					oldest = expected_outcomes.pop_front();
					check_field("status", ath_pkg::TOTAL_W'(rsp.status),
						ath_pkg::TOTAL_W'(oldest.status));
					check_field("slot_index", ath_pkg::TOTAL_W'(rsp.slot_index),
						ath_pkg::TOTAL_W'(oldest.slot_index));
					check_field("occupied_count", ath_pkg::TOTAL_W'(rsp.occupied_count),
						ath_pkg::TOTAL_W'(oldest.occupied_count));
					check_field("kind_total", rsp.kind_total, oldest.kind_total);
				end
				result_count++;
			end
			if (req.valid && req.ready)
				expected_outcomes.push_back(apply_request(req.req_type, req.key, req.kind,
					req.size_amount, req.location_id));
			outstanding <= expected_outcomes.size();
		end
	end

endmodule

[tb/allocation_tracker_hash_table_tb.sv]
// top of the allocation tracker testbench: clock, reset, request stimulus and verdict
// depends on ath_pkg, the channel interfaces, the block and its checker
module allocation_tracker_hash_table_tb;

	localparam int CYCLE_LIMIT   = 5_000_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_ITEMS  = 700;
	localparam int LOAD_CEILING  = 400;

	// kind codes beyond the two the package names
	localparam logic [ath_pkg::KIND_W-1:0] KIND_ALIGNED   = 3'd2;
	localparam logic [ath_pkg::KIND_W-1:0] KIND_MUTEX     = 3'd3;
	localparam logic [ath_pkg::KIND_W-1:0] KIND_SEMAPHORE = 3'd4;
	localparam logic [ath_pkg::KIND_W-1:0] KIND_THREAD    = 3'd5;
	localparam logic [ath_pkg::KIND_W-1:0] KIND_SIX       = 3'd6;
	localparam logic [ath_pkg::KIND_W-1:0] KIND_SEVEN     = 3'd7;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_style_t;

	logic                       clk;
	logic                       arst_n;
	int                         mismatches;
	int                         outstanding;
	int                         cycle_count = 0;
	int                         stall_tick = 0;
	stall_style_t               stall_style;
	bit                         idle_on;
	bit                         req_up;
	int                         burst_left;
	logic [ath_pkg::KEY_W-1:0]  live_keys [$];
	logic [ath_pkg::KIND_W-1:0] live_kinds [$];

	ath_req_if req_ch ();
	ath_rsp_if rsp_ch ();

	allocation_tracker_hash_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	allocation_tracker_hash_table_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		forever begin
			@(posedge clk);
			cycle_count <= cycle_count + 1;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// response side stalls on a pattern of its own
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			stall_tick <= stall_tick + 1;
			case (stall_style)
				STALL_NONE: rsp_ch.ready <= 1'b1;
				STALL_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				STALL_PERIODIC: rsp_ch.ready <= ((stall_tick % 7) >= 3);
				default: rsp_ch.ready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	function automatic logic [ath_pkg::KEY_W-1:0] rand_key();
		logic [ath_pkg::KEY_W-1:0] k;
		k = {$urandom, $urandom};
		if (k == '0)
			k = ath_pkg::KEY_W'(1);
		return k;
	endfunction

	// nonzero key whose hi+lo sum lands on the given home slot
	function automatic logic [ath_pkg::KEY_W-1:0] make_key(int home);
		logic [ath_pkg::HALF_W-1:0] hi;
		logic [ath_pkg::HALF_W-1:0] mix;
		hi = $urandom;
		mix = $urandom;
		mix[ath_pkg::SLOT_W-1:0] = home[ath_pkg::SLOT_W-1:0];
		if (hi == '0 && mix == '0)
			hi = ath_pkg::HALF_W'(1);
		return {hi, mix - hi};
	endfunction

	function automatic logic [ath_pkg::SIZE_W-1:0] rand_size();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return ath_pkg::SIZE_W'($urandom_range(1, 4096));
			default: return ath_pkg::SIZE_W'({$urandom, $urandom});
		endcase
	endfunction

	// mostly tracked kinds, now and then one with no running total
	function automatic logic [ath_pkg::KIND_W-1:0] rand_kind();
		if ($urandom_range(0, 15) == 0)
			return ath_pkg::KIND_W'($urandom_range(KIND_SIX, KIND_SEVEN));
		return ath_pkg::KIND_W'($urandom_range(ath_pkg::KIND_MALLOC, KIND_THREAD));
	endfunction

	// index of a live entry that a remove with this key and kind would retire
	function automatic int find_live(logic [ath_pkg::KEY_W-1:0] k,
			logic [ath_pkg::KIND_W-1:0] kd, bit any_kind);
		foreach (live_keys[i])
			if (live_keys[i] == k && (any_kind || live_kinds[i] == kd ||
					(live_kinds[i] == ath_pkg::KIND_CALLOC && kd == ath_pkg::KIND_MALLOC)))
				return i;
		return -1;
	endfunction

	function automatic logic [ath_pkg::KEY_W-1:0] rand_absent_key();
		logic [ath_pkg::KEY_W-1:0] k;
		do
			k = rand_key();
		while (find_live(k, '0, 1'b1) >= 0);
		return k;
	endfunction

	// drive one item, wait for it to be taken, then maybe close the burst
	task automatic send_request(ath_pkg::req_kind_t op, logic [ath_pkg::KEY_W-1:0] k,
			logic [ath_pkg::KIND_W-1:0] kd, logic [ath_pkg::SIZE_W-1:0] sz,
			logic [ath_pkg::LOC_IN_W-1:0] loc);
		int at;
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= op;
		req_ch.key         <= k;
		req_ch.kind        <= kd;
		req_ch.size_amount <= sz;
		req_ch.location_id <= loc;
		req_up = 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		// keep the list of live entries in step with the block
		if (k != '0 && op == ath_pkg::REQ_ADD && live_keys.size() < ath_pkg::SLOTS) begin
			live_keys.push_back(k);
			live_kinds.push_back(kd);
		end else if (k != '0 && op == ath_pkg::REQ_REMOVE) begin
			at = find_live(k, kd, 1'b0);
			if (at >= 0) begin
				live_keys.delete(at);
				live_kinds.delete(at);
			end
		end
		// a burst ends in a gap of random length
		burst_left--;
		if (idle_on && burst_left <= 0) begin
			req_ch.valid <= 1'b0;
			req_up = 1'b0;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(9, 60)) @(posedge clk);
			else
				repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
	endtask

	// hold off until every expected result is back
	task automatic quiesce();
		if (req_up) begin
			req_ch.valid <= 1'b0;
			req_up = 1'b0;
		end
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// one random item: mostly well-formed adds and removes, some misses and zero keys
	task automatic random_request();
		int                         pick;
		int                         at;
		logic [ath_pkg::KEY_W-1:0]  k;
		logic [ath_pkg::KIND_W-1:0] kd;
		pick = $urandom_range(0, 99);
		if (live_keys.size() == 0 && pick >= 42 && pick <= 87)
			pick = 0;
		if (live_keys.size() > LOAD_CEILING && pick < 49)
			pick = 49 + (pick % 35);
		at = (live_keys.size() > 0) ? $urandom_range(0, live_keys.size() - 1) : 0;
		if (pick < 42) begin
			// fresh entry, some crowded around the last slots so probes wrap
			if ($urandom_range(0, 6) == 0)
				k = make_key(ath_pkg::SLOTS - 1 - $urandom_range(0, 7));
			else
				k = rand_key();
			at = find_live(k, '0, 1'b1);
			kd = (at >= 0) ? live_kinds[at] : rand_kind();
			send_request(ath_pkg::REQ_ADD, k, kd, rand_size(), ath_pkg::LOC_IN_W'($urandom));
		end else if (pick < 49) begin
			// same key again, same kind
			send_request(ath_pkg::REQ_ADD, live_keys[at], live_kinds[at], rand_size(),
				ath_pkg::LOC_IN_W'($urandom));
		end else if (pick < 84) begin
			kd = live_kinds[at];
			if (kd == ath_pkg::KIND_CALLOC && $urandom_range(0, 1) == 1)
				kd = ath_pkg::KIND_MALLOC;
			send_request(ath_pkg::REQ_REMOVE, live_keys[at], kd, rand_size(),
				ath_pkg::LOC_IN_W'($urandom));
		end else if (pick < 88) begin
			// live key under a kind that cannot match it
			do
				kd = ath_pkg::KIND_W'($urandom_range(ath_pkg::KIND_MALLOC, KIND_SEVEN));
			while (kd == live_kinds[at] ||
				(live_kinds[at] == ath_pkg::KIND_CALLOC && kd == ath_pkg::KIND_MALLOC));
			send_request(ath_pkg::REQ_REMOVE, live_keys[at], kd, rand_size(),
				ath_pkg::LOC_IN_W'($urandom));
		end else if (pick < 91) begin
			send_request(ath_pkg::REQ_REMOVE, rand_absent_key(),
				ath_pkg::KIND_W'($urandom_range(ath_pkg::KIND_MALLOC, KIND_SEVEN)),
				rand_size(), ath_pkg::LOC_IN_W'($urandom));
		end else if (pick < 95) begin
			send_request(ath_pkg::REQ_ADD, '0, rand_kind(), rand_size(),
				ath_pkg::LOC_IN_W'($urandom));
		end else begin
			send_request(ath_pkg::REQ_REMOVE, '0,
				ath_pkg::KIND_W'($urandom_range(ath_pkg::KIND_MALLOC, KIND_SEVEN)),
				rand_size(), ath_pkg::LOC_IN_W'($urandom));
		end
	endtask

	initial begin
		logic [ath_pkg::KEY_W-1:0] key_a;
		logic [ath_pkg::KEY_W-1:0] key_b;
		logic [ath_pkg::KEY_W-1:0] key_six;
		logic [ath_pkg::KEY_W-1:0] key_seven;
		logic [ath_pkg::KEY_W-1:0] key_mutex;
		logic [ath_pkg::KEY_W-1:0] key_sem;
		int                        n;

		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= ath_pkg::REQ_ADD;
		req_ch.key <= '0;
		req_ch.kind <= '0;
		req_ch.size_amount <= '0;
		req_ch.location_id <= '0;
		stall_style <= STALL_RANDOM;
		idle_on = 1'b1;
		req_up = 1'b0;
		burst_left = 3;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero keys, miss on an empty table
		send_request(ath_pkg::REQ_ADD, '0, ath_pkg::KIND_MALLOC, '1, '1);
		send_request(ath_pkg::REQ_REMOVE, '0, KIND_MUTEX, '0, '0);
		send_request(ath_pkg::REQ_REMOVE, rand_key(), ath_pkg::KIND_MALLOC, rand_size(), '0);

		// directed: extreme fields, wrap from the last slot, duplicates, every kind
		key_a = make_key(ath_pkg::SLOTS - 1);
		key_b = make_key(ath_pkg::SLOTS - 1);
		key_six = rand_key();
		key_seven = rand_key();
		key_mutex = rand_key();
		key_sem = rand_key();
		send_request(ath_pkg::REQ_ADD, '1, KIND_THREAD, '1, '1);
		send_request(ath_pkg::REQ_ADD, key_a, ath_pkg::KIND_MALLOC, '1, '0);
		send_request(ath_pkg::REQ_ADD, key_b, ath_pkg::KIND_CALLOC, 48'd1, 16'h8000);
		send_request(ath_pkg::REQ_ADD, key_b, ath_pkg::KIND_CALLOC, '1, 16'h7fff);
		send_request(ath_pkg::REQ_ADD, key_six, KIND_SIX, 48'd123, 16'h1234);
		send_request(ath_pkg::REQ_ADD, key_seven, KIND_SEVEN, '1, '1);
		send_request(ath_pkg::REQ_ADD, 64'd1, KIND_ALIGNED, '0, '0);
		send_request(ath_pkg::REQ_ADD, key_mutex, KIND_MUTEX, rand_size(),
			ath_pkg::LOC_IN_W'($urandom));
		send_request(ath_pkg::REQ_ADD, key_sem, KIND_SEMAPHORE, rand_size(),
			ath_pkg::LOC_IN_W'($urandom));

		// directed: untracked kinds, wrong kind, malloc retiring calloc
		send_request(ath_pkg::REQ_REMOVE, key_seven, KIND_SEVEN, '0, '0);
		send_request(ath_pkg::REQ_REMOVE, key_six, KIND_SEVEN, '0, '0);
		send_request(ath_pkg::REQ_REMOVE, key_six, KIND_SIX, '0, '0);
		send_request(ath_pkg::REQ_REMOVE, key_b, ath_pkg::KIND_MALLOC, '0, '0);
		send_request(ath_pkg::REQ_REMOVE, key_a, ath_pkg::KIND_CALLOC, '0, '0);
		send_request(ath_pkg::REQ_REMOVE, key_a, ath_pkg::KIND_MALLOC, '0, '0);
		send_request(ath_pkg::REQ_REMOVE, key_b, ath_pkg::KIND_CALLOC, '0, '0);
		send_request(ath_pkg::REQ_REMOVE, 64'd1, KIND_ALIGNED, '1, '1);
		send_request(ath_pkg::REQ_REMOVE, '1, KIND_THREAD, '0, '0);
		send_request(ath_pkg::REQ_REMOVE, key_mutex, KIND_MUTEX, '0, '0);
		send_request(ath_pkg::REQ_REMOVE, key_sem, KIND_SEMAPHORE, '0, '0);
		quiesce();

		// random traffic, idling style changing every hundred items
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				stall_style <= stall_style_t'($urandom_range(0, 3));
				idle_on = ($urandom_range(0, 2) != 0);
			end
			if ($urandom_range(0, 99) == 0)
				quiesce();
			random_request();
		end
		quiesce();

		// empty the table
		stall_style <= STALL_RANDOM;
		while (live_keys.size() > 0)
			send_request(ath_pkg::REQ_REMOVE, live_keys[0], live_kinds[0], '0, '0);

		quiesce();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
